>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ttc_pkg.sv
package ttc_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int TRIM_SET_MAX  = 8;
  localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);

  localparam int BYTE_W    = 8;
  localparam int SET_W     = 64;
  localparam int SIZE_W    = 4;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_SET      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_SET_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_MODE     = 2'd2;

  // Reset values: space, tab, LF, CR; left and right trim.
  localparam logic [SET_W-1:0]  TRIM_SET_RST  = 64'h0000_0000_0D0A_0920;
  localparam logic [SIZE_W-1:0] TRIM_SIZE_RST = 4'd4;
  localparam logic [MODE_W-1:0] TRIM_MODE_RST = 3'd3;

  // Bit positions in trim_mode.
  localparam int MODE_LEFT     = 0;
  localparam int MODE_RIGHT    = 1;
  localparam int MODE_COLLAPSE = 2;

  typedef struct packed {
    logic take;        // input beat accepted this cycle
    logic emit_entry;  // load output with the pending entry at the read pointer
    logic emit_tail;   // load output with the held byte and close the flush
  } ttc_cmd_t;

  typedef struct packed {
    logic flush;       // the offered byte ends a stored run
    logic out_free;    // output register can take a beat this cycle
    logic entry_last;  // read pointer sits on the last pending entry
  } ttc_status_t;

endpackage

>>> hw/rtl/ttc_if.sv
interface ttc_item_if;
  import ttc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface ttc_result_if;
  import ttc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid;
  logic              out_last;
  logic              out_overflow;
  modport source (output valid, out_byte, out_byte_valid, out_last, out_overflow,
                  input ready);
  modport sink   (input valid, out_byte, out_byte_valid, out_last, out_overflow,
                  output ready);
endinterface

interface ttc_cfg_if;
  import ttc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SET_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/text_trim_collapse.sv
// Streaming string trim and collapse. Bytes arrive on item, one beat per byte,
// with in_last on the final byte; results leave on result, one beat per output
// byte, with out_last on the final beat of the string. A byte is a trim byte
// when it matches one of the first trim_set_size bytes of trim_set (sizes above
// eight count as eight, size zero trims nothing). trim_mode bit 0 drops the
// leading trim bytes, bit 1 drops the trailing ones, bit 2 keeps only the first
// byte of every run. With right trim on, a run is parked in a 32-entry pending
// RAM and replayed ahead of the next kept byte; a run longer than the RAM loses
// its excess and every beat of that replay carries out_overflow. A trailing run
// is silently discarded. A string whose final byte is a trim byte that is not
// shown ends with one end marker beat with out_byte_valid low. Input is taken
// while the controller is idle and the output register is free; a kept byte that
// ends a parked run holds the input while each entry is read from the registered
// read port of the pending RAM and pushed out, then the byte itself. Reset needs
// no clearing pass. Write configuration only while the block is idle.
module text_trim_collapse (
  input  logic          clk,
  input  logic          rst,
  ttc_item_if.sink      item,
  ttc_result_if.source  result,
  ttc_cfg_if.sink       cfg
);
  import ttc_pkg::*;

  ttc_cmd_t    cmd;
  ttc_status_t status;

  // Sequencer: decides when to take a beat and walks the pending run.
  ttc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: registers, trim match, string state, pending RAM, output beat.
  ttc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_byte (item.in_byte),
    .in_last (item.in_last),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

>>> hw/rtl/ttc_ram.sv
module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ttc_datapath.sv
`include "assert_macros.svh"

module ttc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  ttc_cfg_if.sink                      cfg,
  input  logic [ttc_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_last,
  input  ttc_pkg::ttc_cmd_t            cmd,
  output ttc_pkg::ttc_status_t         status,
  ttc_result_if.source                 result
);
  import ttc_pkg::*;

  logic [SET_W-1:0]   trim_set;
  logic [SIZE_W-1:0]  trim_set_size;
  logic [MODE_W-1:0]  trim_mode;

  logic               at_start;
  logic               in_run;
  logic [PEND_CW-1:0] pend_count;
  logic               lost_flag;
  logic [PEND_AW-1:0] rd_idx;

  logic [BYTE_W-1:0]  byte_q;
  logic               last_q;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_byte_valid;
  logic               out_last;
  logic               out_overflow;

  logic               hit;
  logic               dropped;
  logic               keep;
  logic               store;
  logic               pass;
  logic               room;
  logic               take_emit;
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;

  function automatic logic is_trim(input logic [SET_W-1:0]  set,
                                   input logic [SIZE_W-1:0] size,
                                   input logic [BYTE_W-1:0] b);
    logic found;
    found = 1'b0;
    for (int i = 0; i < TRIM_SET_MAX; i++) begin
      if ((SIZE_W'(i) < size) && (set[BYTE_W*i +: BYTE_W] == b)) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

  always_comb begin
    hit       = is_trim(trim_set, trim_set_size, in_byte);
    dropped   = trim_mode[MODE_LEFT] && at_start;
    keep      = !trim_mode[MODE_COLLAPSE] || !in_run;
    store     = hit && !dropped && keep && trim_mode[MODE_RIGHT];
    pass      = hit && !dropped && keep && !trim_mode[MODE_RIGHT];
    room      = pend_count < PEND_CW'(PENDING_DEPTH);
    take_emit = pass || (!hit && (pend_count == '0)) || (hit && in_last);
    ram_we    = cmd.take && store && room;

    status.flush      = !hit && (pend_count != '0);
    status.out_free   = !out_valid || result.ready;
    status.entry_last = (PEND_CW'(rd_idx) + PEND_CW'(1)) == pend_count;
  end

  ttc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_count[PEND_AW-1:0]),
    .wdata (in_byte),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_set      <= TRIM_SET_RST;
      trim_set_size <= TRIM_SIZE_RST;
      trim_mode     <= TRIM_MODE_RST;
      at_start      <= 1'b1;
      in_run        <= 1'b0;
      pend_count    <= '0;
      lost_flag     <= 1'b0;
      rd_idx        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_TRIM_SET:      trim_set      <= cfg.data;
          CFG_TRIM_SET_SIZE: trim_set_size <= cfg.data[SIZE_W-1:0];
          CFG_TRIM_MODE:     trim_mode     <= cfg.data[MODE_W-1:0];
          default: ;
        endcase
      end

      if (cmd.take) begin
        rd_idx <= '0;
        if (hit) begin
          if (!dropped) begin
            in_run <= 1'b1;
          end
          if (store) begin
            if (room) begin
              pend_count <= pend_count + PEND_CW'(1);
            end else begin
              lost_flag <= 1'b1;
            end
          end
        end else begin
          at_start <= 1'b0;
          in_run   <= 1'b0;
          if (pend_count == '0) begin
            lost_flag <= 1'b0;
          end
        end
        if (in_last) begin
          at_start <= 1'b1;
          in_run   <= 1'b0;
          if (hit) begin
            pend_count <= '0;
            lost_flag  <= 1'b0;
          end
        end
      end

      if (cmd.emit_entry) begin
        rd_idx <= rd_idx + PEND_AW'(1);
      end

      if (cmd.emit_tail) begin
        pend_count <= '0;
        lost_flag  <= 1'b0;
      end

      if ((cmd.take && take_emit) || cmd.emit_entry || cmd.emit_tail) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
    if (cmd.take && take_emit) begin
      if (!hit) begin
        out_byte       <= in_byte;
        out_byte_valid <= 1'b1;
        out_last       <= in_last;
        out_overflow   <= lost_flag;
      end else if (pass) begin
        out_byte       <= in_byte;
        out_byte_valid <= 1'b1;
        out_last       <= in_last;
        out_overflow   <= 1'b0;
      end else begin
        out_byte       <= '0;
        out_byte_valid <= 1'b0;
        out_last       <= 1'b1;
        out_overflow   <= 1'b0;
      end
    end else if (cmd.emit_entry) begin
      out_byte       <= ram_rdata;
      out_byte_valid <= 1'b1;
      out_last       <= 1'b0;
      out_overflow   <= lost_flag;
    end else if (cmd.emit_tail) begin
      out_byte       <= byte_q;
      out_byte_valid <= 1'b1;
      out_last       <= last_q;
      out_overflow   <= lost_flag;
    end
  end

  assign result.valid          = out_valid;
  assign result.out_byte       = out_byte;
  assign result.out_byte_valid = out_byte_valid;
  assign result.out_last       = out_last;
  assign result.out_overflow   = out_overflow;

  `ASSERT_CLK(a_tail_closes_run, clk, rst, cmd.emit_tail |=> ((pend_count == '0) && out_valid), "flush end left pending bytes or no beat")
  `ASSERT_CLK(a_entry_in_range, clk, rst, cmd.emit_entry |-> (PEND_CW'(rd_idx) < pend_count), "flush read past the pending run")

endmodule

>>> hw/rtl/ttc_ctrl.sv
`include "assert_macros.svh"

module ttc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttc_pkg::ttc_status_t  status,
  output ttc_pkg::ttc_cmd_t     cmd
);
  import ttc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_PUSH = 4'b0100,
    S_TAIL = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready       = (state == S_IDLE) && status.out_free;
    cmd.take       = in_valid && in_ready;
    cmd.emit_entry = (state == S_PUSH) && status.out_free;
    cmd.emit_tail  = (state == S_TAIL) && status.out_free;

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && status.flush) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_PUSH;
      S_PUSH: begin
        if (status.out_free) begin
          state_next = status.entry_last ? S_TAIL : S_READ;
        end
      end
      S_TAIL: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_CLK_ALWAYS(a_reset_to_idle, clk, rst |=> (state == S_IDLE), "controller not idle after reset")
  `ASSERT_CLK(a_flush_starts, clk, rst, (cmd.take && status.flush) |=> (state == S_READ), "flush did not start")
  `ASSERT_CLK(a_tail_returns, clk, rst, cmd.emit_tail |=> (state == S_IDLE), "controller stuck after flush")

endmodule
